// ===== rtl/xfse_pkg.sv =====
// shared types, constants and bit-count functions of the xor float stream encoder
package xfse_pkg;

    localparam int VALUE_W    = 64;
    localparam int CODE_W     = 75;
    localparam int BUF_W      = 88;
    localparam int NBITS_W    = 7;
    localparam int BIDX_W     = 4;
    localparam int CAP_W      = 16;
    localparam int APB_ADDR_W = 3;
    localparam int APB_DATA_W = 32;

    localparam int LZ_BITS_32  = 3;
    localparam int LZ_BITS_64  = 4;
    localparam int LEN_BITS_32 = 5;
    localparam int LEN_BITS_64 = 6;
    localparam int HDR_BITS_32 = 1 + LZ_BITS_32 + LEN_BITS_32;
    localparam int HDR_BITS_64 = 1 + LZ_BITS_64 + LEN_BITS_64;

    localparam logic [15:0] CAP_RESET = 16'd8192;

    localparam logic [1:0] KIND_BYTE  = 2'd0;
    localparam logic [1:0] KIND_FIRST = 2'd1;
    localparam logic [1:0] KIND_SUM   = 2'd2;

    localparam logic [1:0] STAT_OK   = 2'd0;
    localparam logic [1:0] STAT_FEW  = 2'd1;
    localparam logic [1:0] STAT_OVF  = 2'd2;

    localparam logic REG_WIDTH_MODE = 1'b0;
    localparam logic REG_CAPACITY   = 1'b1;

    typedef enum logic [1:0] {
        PH_FIRST,
        PH_BYTE,
        PH_SUM
    } t_phase;

    function automatic logic [NBITS_W-1:0] lzc64(input logic [VALUE_W-1:0] x);
        logic [NBITS_W-1:0] n;
        logic               found;
        n     = NBITS_W'(VALUE_W);
        found = 1'b0;
        for (int i = VALUE_W - 1; i >= 0; i--) begin
            if (!found && x[i]) begin
                n     = NBITS_W'(VALUE_W - 1 - i);
                found = 1'b1;
            end
        end
        return n;
    endfunction

    function automatic logic [NBITS_W-1:0] tzc64(input logic [VALUE_W-1:0] x);
        logic [NBITS_W-1:0] n;
        logic               found;
        n     = NBITS_W'(VALUE_W);
        found = 1'b0;
        for (int i = 0; i < VALUE_W; i++) begin
            if (!found && x[i]) begin
                n     = NBITS_W'(i);
                found = 1'b1;
            end
        end
        return n;
    endfunction

endpackage

// ===== rtl/xfse_if.sv =====
// stream interfaces for the input items and the result beats

interface xfse_in_if;
    logic        valid;
    logic        ready;
    logic [63:0] value;
    logic        is_null;
    logic        end_of_block;

    modport source (output valid, output value, output is_null, output end_of_block,
                    input ready);
    modport sink   (input valid, input value, input is_null, input end_of_block,
                    output ready);
endinterface

interface xfse_out_if;
    logic        valid;
    logic        ready;
    logic [1:0]  result_kind;
    logic [63:0] payload;
    logic [15:0] byte_total;
    logic [15:0] value_count;
    logic [1:0]  status;
    logic        last;

    modport source (output valid, output result_kind, output payload, output byte_total,
                    output value_count, output status, output last, input ready);
    modport sink   (input valid, input result_kind, input payload, input byte_total,
                    input value_count, input status, input last, output ready);
endinterface

// ===== rtl/xor_float_stream_encoder_top.sv =====
// top level of the xor float stream encoder: xor coding, bit packing and result serializer
//
// channel   dir  beat contents
// i_in      in   value, is_null, end_of_block
// o_out     out  result_kind, payload, byte_total, value_count, status, last
// apb       in   width_mode at 0x0, stream_capacity at 0x4
//
// input and xor coding registers feed the bit merge, whose packet register feeds the serializer
// the serializer sends one result beat per cycle while o_out is not stalled; an item has
// up to 12 results, and a byte run that finds the capacity used up takes a step with no beat
// items with no result skip the packet register; beats pass coding, packet and output registers
// reset is synchronous and clears all block state; there is no clearing pass
// a stalled o_out holds the output register and backs up to i_in.ready

module xor_float_stream_encoder_top #(
    parameter int COUNT_WIDTH = 16
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               psel,
    input  logic                               penable,
    input  logic                               pwrite,
    input  logic [xfse_pkg::APB_ADDR_W-1:0]    paddr,
    input  logic [xfse_pkg::APB_DATA_W-1:0]    pwdata,
    output logic [xfse_pkg::APB_DATA_W-1:0]    prdata,
    output logic                               pready,
    xfse_in_if.sink                            i_in,
    xfse_out_if.source                         o_out
);

    // configuration
    logic                        r_mode;
    logic [xfse_pkg::CAP_W-1:0]  r_cap;
    logic                        cfg_wr;

    // input stage
    logic        r_s1_vld;
    logic [63:0] r_s1_value;
    logic        r_s1_null;
    logic        r_s1_eob;

    // block state of the coding stage
    logic [63:0]            r_prev;
    logic                   r_have;
    logic [COUNT_WIDTH-1:0] r_vseen;

    // coding stage
    logic                                r_s2_vld;
    logic                                r_s2_first;
    logic [63:0]                         r_s2_fval;
    logic [xfse_pkg::CODE_W-1:0]         r_s2_code;
    logic [xfse_pkg::NBITS_W-1:0]        r_s2_nnew;
    logic                                r_s2_eob;
    logic [COUNT_WIDTH-1:0]              r_s2_vcnt;

    // pending bits of the merge stage
    logic [6:0] r_pend_bits;
    logic [2:0] r_pend_cnt;

    // packet register
    logic                               r_pk_vld;
    logic [xfse_pkg::BUF_W-1:0]         r_pk_bits;
    logic [xfse_pkg::BIDX_W-1:0]        r_pk_nbytes;
    logic [63:0]                        r_pk_fval;
    logic                               r_pk_eob;
    logic [COUNT_WIDTH-1:0]             r_pk_vcnt;

    // serializer
    xfse_pkg::t_phase                   r_ph;
    xfse_pkg::t_phase                   n_ph;
    logic [xfse_pkg::BIDX_W-1:0]        r_bidx;
    logic [xfse_pkg::BIDX_W-1:0]        n_bidx;
    logic [xfse_pkg::CAP_W-1:0]         r_be;
    logic                               r_ovf;

    // output register
    logic        r_out_vld;
    logic [1:0]  r_out_kind;
    logic [63:0] r_out_payload;
    logic [15:0] r_out_pbytes;
    logic [15:0] r_out_vcount;
    logic [1:0]  r_out_status;
    logic        r_out_last;

    // handshake
    logic out_free;
    logic step;
    logic ser_done;
    logic pk_free;
    logic pk_load;
    logic s2_adv;
    logic s1_adv;
    logic in_acc;

    // ---------------------------------------------------------------- config port
    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite;

    always_comb begin
        unique case (paddr[2])
            xfse_pkg::REG_WIDTH_MODE: prdata = {31'b0, r_mode};
            xfse_pkg::REG_CAPACITY:   prdata = {16'b0, r_cap};
            default:                  prdata = '0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode <= 1'b1;
            r_cap  <= xfse_pkg::CAP_RESET;
        end else if (cfg_wr) begin
            unique case (paddr[2])
                xfse_pkg::REG_WIDTH_MODE: r_mode <= pwdata[0];
                xfse_pkg::REG_CAPACITY:   r_cap  <= pwdata[15:0];
                default:                  r_mode <= r_mode;
            endcase
        end
    end

    // ---------------------------------------------------------------- handshake chain
    assign out_free = !r_out_vld || o_out.ready;
    assign step     = r_pk_vld && out_free;
    assign pk_free  = !r_pk_vld || ser_done;
    assign s2_adv   = r_s2_vld && pk_free;
    assign s1_adv   = r_s1_vld && (!r_s2_vld || s2_adv);
    assign i_in.ready = !r_s1_vld || s1_adv;
    assign in_acc   = i_in.valid && i_in.ready;

    // ---------------------------------------------------------------- input stage
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_vld <= 1'b0;
        end else if (in_acc) begin
            r_s1_vld <= 1'b1;
        end else if (s1_adv) begin
            r_s1_vld <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            r_s1_value <= i_in.value;
            r_s1_null  <= i_in.is_null;
            r_s1_eob   <= i_in.end_of_block;
        end
    end

    // ---------------------------------------------------------------- xor coding
    logic [63:0]                  s1_v;
    logic [63:0]                  s1_x;
    logic [63:0]                  s1_xa;
    logic [xfse_pkg::NBITS_W-1:0] s1_lz;
    logic [xfse_pkg::NBITS_W-1:0] s1_tz;
    logic [3:0]                   s1_bucket;
    logic [xfse_pkg::NBITS_W-1:0] s1_mb;
    logic [xfse_pkg::NBITS_W-1:0] s1_mb_m1;
    logic [63:0]                  s1_sh;
    logic [10:0]                  s1_hdr;
    logic [xfse_pkg::CODE_W-1:0]  s1_code;
    logic [xfse_pkg::NBITS_W-1:0] s1_nnew;
    logic                         s1_first;
    logic                         s1_enc;
    logic [COUNT_WIDTH-1:0]       s1_vinc;
    logic                         s1_keep;

    always_comb begin
        s1_v      = r_mode ? r_s1_value : {32'b0, r_s1_value[31:0]};
        s1_x      = r_mode ? (s1_v ^ r_prev) : {32'b0, s1_v[31:0] ^ r_prev[31:0]};
        s1_xa     = r_mode ? s1_x : {s1_x[31:0], 32'b0};
        s1_lz     = xfse_pkg::lzc64(s1_xa);
        s1_tz     = xfse_pkg::tzc64(s1_x);
        s1_bucket = s1_lz[5:2];
        s1_mb     = (r_mode ? 7'd64 : 7'd32) - {1'b0, s1_bucket, 2'b00} - s1_tz;
        s1_mb_m1  = s1_mb - 7'd1;
        s1_sh     = s1_x >> s1_tz;
        s1_hdr    = r_mode ? {s1_mb_m1[5:0], s1_bucket, 1'b1}
                           : {2'b00, s1_mb_m1[4:0], s1_bucket[2:0], 1'b1};
        s1_first  = !r_s1_null && !r_have;
        s1_enc    = !r_s1_null && r_have;
        s1_keep   = !r_s1_null || r_s1_eob;
        s1_vinc   = (!r_s1_null && (r_vseen != '1)) ? r_vseen + 1'b1 : r_vseen;

        if (s1_enc && (s1_x != '0)) begin
            if (r_mode) begin
                s1_code = (xfse_pkg::CODE_W'(s1_sh) << xfse_pkg::HDR_BITS_64)
                        | xfse_pkg::CODE_W'(s1_hdr);
                s1_nnew = 7'(xfse_pkg::HDR_BITS_64) + s1_mb;
            end else begin
                s1_code = (xfse_pkg::CODE_W'(s1_sh) << xfse_pkg::HDR_BITS_32)
                        | xfse_pkg::CODE_W'(s1_hdr);
                s1_nnew = 7'(xfse_pkg::HDR_BITS_32) + s1_mb;
            end
        end else if (s1_enc) begin
            s1_code = '0;
            s1_nnew = 7'd1;
        end else begin
            s1_code = '0;
            s1_nnew = '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_prev   <= '0;
            r_have   <= 1'b0;
            r_vseen  <= '0;
            r_s2_vld <= 1'b0;
        end else begin
            if (s1_adv) begin
                if (r_s1_eob) begin
                    r_prev  <= '0;
                    r_have  <= 1'b0;
                    r_vseen <= '0;
                end else if (!r_s1_null) begin
                    r_prev  <= s1_v;
                    r_have  <= 1'b1;
                    r_vseen <= s1_vinc;
                end
            end
            if (s1_adv && s1_keep) begin
                r_s2_vld <= 1'b1;
            end else if (s2_adv) begin
                r_s2_vld <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (s1_adv && s1_keep) begin
            r_s2_first <= s1_first;
            r_s2_fval  <= s1_v;
            r_s2_code  <= s1_code;
            r_s2_nnew  <= s1_nnew;
            r_s2_eob   <= r_s1_eob;
            r_s2_vcnt  <= s1_vinc;
        end
    end

    // ---------------------------------------------------------------- bit merge
    logic [xfse_pkg::BUF_W-1:0]   s2_buf;
    logic [xfse_pkg::NBITS_W-1:0] s2_tot;
    logic [xfse_pkg::NBITS_W-1:0] s2_tot_up;
    logic [xfse_pkg::BIDX_W-1:0]  s2_nfull;
    logic [xfse_pkg::BIDX_W-1:0]  s2_nbytes;
    logic [6:0]                   s2_pend;
    logic                         s2_has_res;
    xfse_pkg::t_phase             s2_start;

    always_comb begin
        s2_buf     = (xfse_pkg::BUF_W'(r_s2_code) << r_pend_cnt)
                   | xfse_pkg::BUF_W'(r_pend_bits);
        s2_tot     = 7'(r_pend_cnt) + r_s2_nnew;
        s2_tot_up  = s2_tot + 7'd7;
        s2_nfull   = s2_tot[6:3];
        s2_nbytes  = r_s2_eob ? s2_tot_up[6:3] : s2_nfull;
        s2_pend    = s2_buf[{s2_nfull, 3'b000} +: 7];
        s2_has_res = r_s2_first || (s2_nbytes != '0) || r_s2_eob;
        if (r_s2_first) begin
            s2_start = xfse_pkg::PH_FIRST;
        end else if (s2_nbytes != '0) begin
            s2_start = xfse_pkg::PH_BYTE;
        end else begin
            s2_start = xfse_pkg::PH_SUM;
        end
    end

    assign pk_load = s2_adv && s2_has_res;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pend_bits <= '0;
            r_pend_cnt  <= '0;
            r_pk_vld    <= 1'b0;
        end else begin
            if (s2_adv) begin
                r_pend_bits <= r_s2_eob ? 7'd0 : s2_pend;
                r_pend_cnt  <= r_s2_eob ? 3'd0 : s2_tot[2:0];
            end
            if (pk_load) begin
                r_pk_vld <= 1'b1;
            end else if (ser_done) begin
                r_pk_vld <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (pk_load) begin
            r_pk_bits   <= s2_buf;
            r_pk_nbytes <= s2_nbytes;
            r_pk_fval   <= r_s2_fval;
            r_pk_eob    <= r_s2_eob;
            r_pk_vcnt   <= r_s2_vcnt;
        end
    end

    // ---------------------------------------------------------------- serializer
    logic                         room;
    logic                         cap_last;
    logic                         byte_end;
    logic [xfse_pkg::BIDX_W-1:0]  bidx_inc;

    assign room     = r_be < r_cap;
    assign cap_last = ({1'b0, r_be} + 17'd1) >= {1'b0, r_cap};
    assign bidx_inc = r_bidx + 1'b1;
    assign byte_end = bidx_inc == r_pk_nbytes;

    // next state
    always_comb begin
        n_ph     = r_ph;
        n_bidx   = r_bidx;
        ser_done = 1'b0;
        if (step) begin
            unique case (r_ph)
                xfse_pkg::PH_FIRST: begin
                    n_bidx = '0;
                    if (r_pk_nbytes != '0) begin
                        n_ph = xfse_pkg::PH_BYTE;
                    end else if (r_pk_eob) begin
                        n_ph = xfse_pkg::PH_SUM;
                    end else begin
                        ser_done = 1'b1;
                    end
                end
                xfse_pkg::PH_BYTE: begin
                    if (room && !byte_end && !cap_last) begin
                        n_bidx = bidx_inc;
                    end else if (r_pk_eob) begin
                        n_ph = xfse_pkg::PH_SUM;
                    end else begin
                        ser_done = 1'b1;
                    end
                end
                xfse_pkg::PH_SUM: begin
                    ser_done = 1'b1;
                end
                default: begin
                    ser_done = 1'b1;
                end
            endcase
        end
        if (pk_load) begin
            n_ph   = s2_start;
            n_bidx = '0;
        end
    end

    // outputs
    logic        ser_emit;
    logic        ser_be_inc;
    logic        ser_ovf_set;
    logic        ser_clear;
    logic [1:0]  ser_kind;
    logic [63:0] ser_payload;
    logic [15:0] ser_pbytes;
    logic [15:0] ser_vcount;
    logic [1:0]  ser_status;
    logic        ser_last;

    always_comb begin
        ser_emit    = 1'b0;
        ser_be_inc  = 1'b0;
        ser_ovf_set = 1'b0;
        ser_clear   = 1'b0;
        ser_kind    = xfse_pkg::KIND_BYTE;
        ser_payload = '0;
        ser_pbytes  = '0;
        ser_vcount  = '0;
        ser_status  = xfse_pkg::STAT_OK;
        ser_last    = 1'b0;
        unique case (r_ph)
            xfse_pkg::PH_FIRST: begin
                ser_emit    = 1'b1;
                ser_kind    = xfse_pkg::KIND_FIRST;
                ser_payload = r_pk_fval;
                ser_last    = !r_pk_eob && ((r_pk_nbytes == '0) || !room);
            end
            xfse_pkg::PH_BYTE: begin
                if (room) begin
                    ser_emit    = 1'b1;
                    ser_be_inc  = 1'b1;
                    ser_kind    = xfse_pkg::KIND_BYTE;
                    ser_payload = {56'b0, r_pk_bits[{r_bidx, 3'b000} +: 8]};
                    ser_last    = !r_pk_eob && (byte_end || cap_last);
                    ser_ovf_set = cap_last && !byte_end;
                end else begin
                    ser_ovf_set = 1'b1;
                end
            end
            xfse_pkg::PH_SUM: begin
                ser_emit   = 1'b1;
                ser_clear  = 1'b1;
                ser_kind   = xfse_pkg::KIND_SUM;
                ser_pbytes = r_be;
                ser_vcount = 16'(r_pk_vcnt);
                ser_last   = 1'b1;
                if (r_pk_vcnt < COUNT_WIDTH'(2)) begin
                    ser_status = xfse_pkg::STAT_FEW;
                end else if (r_ovf) begin
                    ser_status = xfse_pkg::STAT_OVF;
                end else begin
                    ser_status = xfse_pkg::STAT_OK;
                end
            end
            default: begin
                ser_emit = 1'b0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ph      <= xfse_pkg::PH_FIRST;
            r_bidx    <= '0;
            r_be      <= '0;
            r_ovf     <= 1'b0;
            r_out_vld <= 1'b0;
        end else begin
            r_ph   <= n_ph;
            r_bidx <= n_bidx;
            if (step) begin
                if (ser_clear) begin
                    r_be  <= '0;
                    r_ovf <= 1'b0;
                end else begin
                    if (ser_be_inc) begin
                        r_be <= r_be + 1'b1;
                    end
                    if (ser_ovf_set) begin
                        r_ovf <= 1'b1;
                    end
                end
            end
            if (step && ser_emit) begin
                r_out_vld <= 1'b1;
            end else if (o_out.ready) begin
                r_out_vld <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (step && ser_emit) begin
            r_out_kind    <= ser_kind;
            r_out_payload <= ser_payload;
            r_out_pbytes  <= ser_pbytes;
            r_out_vcount  <= ser_vcount;
            r_out_status  <= ser_status;
            r_out_last    <= ser_last;
        end
    end

    assign o_out.valid        = r_out_vld;
    assign o_out.result_kind  = r_out_kind;
    assign o_out.payload      = r_out_payload;
    assign o_out.byte_total   = r_out_pbytes;
    assign o_out.value_count  = r_out_vcount;
    assign o_out.status       = r_out_status;
    assign o_out.last         = r_out_last;

endmodule

// ===== dv/xfse_encoder_checker.sv =====
// result stream checker for the xor float stream encoder: predicts beats and compares them
`timescale 1ns / 100ps

module xfse_encoder_checker #(
    parameter int COUNT_WIDTH = 16
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            psel,
    input  logic                            penable,
    input  logic                            pwrite,
    input  logic                            pready,
    input  logic [xfse_pkg::APB_ADDR_W-1:0] paddr,
    input  logic [xfse_pkg::APB_DATA_W-1:0] pwdata,
    xfse_in_if                              i_in,
    xfse_out_if                             i_out,
    output int                              o_fail_count,
    output int                              o_waiting
);

    localparam longint TALLY_MAX = (longint'(1) << COUNT_WIDTH) - 1;

    typedef struct {
        logic [1:0]  kind;
        logic [63:0] payload;
        logic [15:0] nbytes;
        logic [15:0] nvalues;
        logic [1:0]  status;
        logic        last;
    } t_enc_beat;

    t_enc_beat   expected_beats[$];

    logic        width_mode;
    logic [15:0] capacity;

    logic [63:0] prev_word;
    logic        have_first;
    logic [7:0]  acc_bits;
    int          acc_cnt;
    int          stream_bytes;
    longint      value_tally;
    logic        overflow;
    int          fail_count;

    task automatic report_mismatch(input string what, input logic [63:0] got,
                                   input logic [63:0] want);
        $display("mismatch at %0t: %s got 0x%0h expected 0x%0h", $realtime, what, got, want);
        fail_count++;
    endtask

    function automatic void clear_block();
        prev_word    = '0;
        have_first   = 1'b0;
        acc_bits     = '0;
        acc_cnt      = 0;
        stream_bytes = 0;
        value_tally  = 0;
        overflow     = 1'b0;
    endfunction

    function automatic void add_beat(input logic [1:0] kind, input logic [63:0] payload,
                                     input logic [15:0] nbytes, input logic [15:0] nvalues,
                                     input logic [1:0] status);
        t_enc_beat b;
        b.kind    = kind;
        b.payload = payload;
        b.nbytes  = nbytes;
        b.nvalues = nvalues;
        b.status  = status;
        b.last    = 1'b0;
        expected_beats.push_back(b);
    endfunction

    function automatic void emit_stream_byte(input logic [7:0] b);
        if (stream_bytes < int'(capacity)) begin
            add_beat(xfse_pkg::KIND_BYTE, {56'd0, b}, '0, '0, xfse_pkg::STAT_OK);
            stream_bytes++;
        end else begin
            overflow = 1'b1;
        end
    endfunction

    function automatic void pack_bits(input logic [63:0] v, input int n);
        for (int i = 0; i < n; i++) begin
            acc_bits[acc_cnt] = v[i];
            acc_cnt++;
            if (acc_cnt == 8) begin
                emit_stream_byte(acc_bits);
                acc_bits = '0;
                acc_cnt  = 0;
            end
        end
    endfunction

    function automatic void encode_item(input logic [63:0] val, input logic nul,
                                        input logic eob);
        logic        wide;
        int          w;
        logic [63:0] mask;
        logic [63:0] word;
        logic [63:0] diff;
        logic [1:0]  status;
        int          lz;
        int          tz;
        int          bucket;
        int          mb;
        int          start;
        t_enc_beat   tail;
        wide  = width_mode;
        w     = wide ? 64 : 32;
        mask  = wide ? '1 : 64'h0000_0000_FFFF_FFFF;
        start = expected_beats.size();
        if (!nul) begin
            word = val & mask;
            if (value_tally < TALLY_MAX) value_tally++;
            if (!have_first) begin
                add_beat(xfse_pkg::KIND_FIRST, word, '0, '0, xfse_pkg::STAT_OK);
                have_first = 1'b1;
            end else begin
                diff = (word ^ prev_word) & mask;
                if (diff == '0) begin
                    pack_bits(64'd0, 1);
                end else begin
                    lz = 0;
                    while (lz < w && !diff[w-1-lz]) lz++;
                    tz = 0;
                    while (!diff[tz]) tz++;
                    bucket = lz / 4;
                    if (bucket > (wide ? 15 : 7)) bucket = wide ? 15 : 7;
                    mb = w - 4 * bucket - tz;
                    pack_bits(64'd1, 1);
                    pack_bits(64'(bucket), wide ? xfse_pkg::LZ_BITS_64 : xfse_pkg::LZ_BITS_32);
                    pack_bits(64'(mb - 1), wide ? xfse_pkg::LEN_BITS_64
                                                : xfse_pkg::LEN_BITS_32);
                    pack_bits(diff >> tz, mb);
                end
            end
            prev_word = word;
        end
        if (eob) begin
            if (acc_cnt > 0) begin
                emit_stream_byte(acc_bits);
                acc_bits = '0;
                acc_cnt  = 0;
            end
            if (value_tally < 2)  status = xfse_pkg::STAT_FEW;
            else if (overflow)    status = xfse_pkg::STAT_OVF;
            else                  status = xfse_pkg::STAT_OK;
            add_beat(xfse_pkg::KIND_SUM, 64'd0, 16'(stream_bytes), 16'(value_tally), status);
            clear_block();
        end
        if (expected_beats.size() > start) begin
            tail      = expected_beats[expected_beats.size()-1];
            tail.last = 1'b1;
            expected_beats[expected_beats.size()-1] = tail;
        end
    endfunction

    always @(posedge i_clk) begin
        t_enc_beat want;
        if (!i_rst_n) begin
            clear_block();
            width_mode = 1'b1;
            capacity   = xfse_pkg::CAP_RESET;
            fail_count = 0;
            expected_beats.delete();
        end else begin
            if (psel && penable && pwrite && pready) begin
                case (paddr[xfse_pkg::APB_ADDR_W-1:2])
                    xfse_pkg::REG_WIDTH_MODE: width_mode = pwdata[0];
                    xfse_pkg::REG_CAPACITY:   capacity   = pwdata[15:0];
                    default: ;
                endcase
            end
            if (i_in.valid && i_in.ready) begin
                encode_item(i_in.value, i_in.is_null, i_in.end_of_block);
            end
            if (i_out.valid && i_out.ready) begin
                if (expected_beats.size() == 0) begin
                    report_mismatch("unexpected beat, result_kind", 64'(i_out.result_kind),
                                    64'(xfse_pkg::KIND_BYTE));
                end else begin
                    want = expected_beats.pop_front();
                    if (i_out.result_kind !== want.kind)
                        report_mismatch("result_kind", 64'(i_out.result_kind), 64'(want.kind));
                    if (i_out.payload !== want.payload)
                        report_mismatch("payload", i_out.payload, want.payload);
                    if (i_out.byte_total !== want.nbytes)
                        report_mismatch("byte_total", 64'(i_out.byte_total),
                                        64'(want.nbytes));
                    if (i_out.value_count !== want.nvalues)
                        report_mismatch("value_count", 64'(i_out.value_count),
                                        64'(want.nvalues));
                    if (i_out.status !== want.status)
                        report_mismatch("status", 64'(i_out.status), 64'(want.status));
                    if (i_out.last !== want.last)
                        report_mismatch("last", 64'(i_out.last), 64'(want.last));
                end
            end
        end
        o_fail_count <= fail_count;
        o_waiting    <= expected_beats.size();
    end

endmodule

// ===== dv/xor_float_stream_encoder_top_tb.sv =====
// testbench top for the xor float stream encoder: clock, reset, stimulus and verdict
`timescale 1ns / 100ps

module xor_float_stream_encoder_top_tb;

    localparam int CYCLE_LIMIT = 1000000;
    localparam int DRAIN_PAUSE = 8;

    logic                            i_clk;
    logic                            i_rst_n;
    logic                            psel;
    logic                            penable;
    logic                            pwrite;
    logic [xfse_pkg::APB_ADDR_W-1:0] paddr;
    logic [xfse_pkg::APB_DATA_W-1:0] pwdata;
    logic [xfse_pkg::APB_DATA_W-1:0] prdata;
    logic                            pready;

    int                    fail_total;
    int                    waiting;
    int                    cycle_count;
    int                    burst_left;
    int                    stall_age;
    logic [15:0]           stall_pattern;
    bit                    tx_steady;
    bit                    rx_steady;

    xfse_in_if  in_ch ();
    xfse_out_if out_ch ();

    xor_float_stream_encoder_top #(
        .COUNT_WIDTH (16)
    ) dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .i_in    (in_ch),
        .o_out   (out_ch)
    );

    xfse_encoder_checker #(
        .COUNT_WIDTH (16)
    ) u_chk (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .psel         (psel),
        .penable      (penable),
        .pwrite       (pwrite),
        .pready       (pready),
        .paddr        (paddr),
        .pwdata       (pwdata),
        .i_in         (in_ch),
        .i_out        (out_ch),
        .o_fail_count (fail_total),
        .o_waiting    (waiting)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("TEST FAILED");
            $finish;
        end
    end

    // result side stalls on a rotating pattern, reloaded now and then
    always @(posedge i_clk) begin
        if (stall_age == 0) begin
            stall_age = $urandom_range(20, 80);
            case ($urandom_range(0, 3))
                0:       stall_pattern = '1;
                1:       stall_pattern = 16'($urandom);
                2:       stall_pattern = 16'h00FF;
                default: stall_pattern = 16'($urandom) | 16'($urandom);
            endcase
        end
        stall_age--;
        stall_pattern = {stall_pattern[14:0], stall_pattern[15]};
        out_ch.ready <= rx_steady | stall_pattern[0];
    end

    task automatic reg_write(input logic idx, input logic [31:0] data);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= xfse_pkg::APB_ADDR_W'({idx, 2'b00});
        pwdata  <= data;
        @(posedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(posedge i_clk);
    endtask

    task automatic send_item(input logic [63:0] word, input logic nul, input logic eob);
        if (!tx_steady && burst_left == 0) begin
            burst_left = $urandom_range(1, 16);
            in_ch.valid <= 1'b0;
            repeat ($urandom_range(1, 8)) @(posedge i_clk);
        end
        if (burst_left > 0) burst_left--;
        in_ch.valid        <= 1'b1;
        in_ch.value        <= word;
        in_ch.is_null      <= nul;
        in_ch.end_of_block <= eob;
        do @(posedge i_clk); while (!in_ch.ready);
    endtask

    task automatic wait_for_drain();
        in_ch.valid <= 1'b0;
        do @(posedge i_clk); while (waiting != 0);
        repeat (DRAIN_PAUSE) @(posedge i_clk);
    endtask

    initial begin
        logic [63:0] word;
        logic [63:0] last_word;
        logic        nul;
        logic        eob;
        logic        mode;
        logic [15:0] cap;
        int          random_items;
        int          phase_items;
        int          block_left;
        burst_left   = 0;
        tx_steady    = 1'b0;
        rx_steady    = 1'b0;
        random_items = 0;
        last_word    = '0;
        i_rst_n            <= 1'b0;
        psel               <= 1'b0;
        penable            <= 1'b0;
        pwrite             <= 1'b0;
        paddr              <= '0;
        pwdata             <= '0;
        in_ch.valid        <= 1'b0;
        in_ch.value        <= '0;
        in_ch.is_null      <= 1'b0;
        in_ch.end_of_block <= 1'b0;
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // 64-bit words, widest capacity
        reg_write(xfse_pkg::REG_CAPACITY, 32'h0000_FFFF);
        send_item(64'h0123_4567_89AB_CDEF, 1'b1, 1'b0);
        send_item(64'hFFFF_FFFF_FFFF_FFFF, 1'b1, 1'b1);
        send_item(64'hFFFF_FFFF_FFFF_FFFF, 1'b0, 1'b0);
        send_item(64'hFFFF_FFFF_FFFF_FFFF, 1'b0, 1'b0);
        send_item(64'h0000_0000_0000_0000, 1'b0, 1'b0);
        send_item(64'h0000_0000_0000_0001, 1'b0, 1'b0);
        send_item(64'h8000_0000_0000_0001, 1'b0, 1'b0);
        send_item(64'h5555_5555_5555_5555, 1'b1, 1'b0);
        send_item(64'hAAAA_AAAA_AAAA_AAAA, 1'b0, 1'b1);
        send_item(64'h3FF0_0000_0000_0000, 1'b0, 1'b1);
        send_item(64'h7FF8_0000_0000_0000, 1'b0, 1'b0);
        send_item(64'hFFF0_0000_0000_0000, 1'b0, 1'b0);
        send_item(64'h0000_0000_0000_0000, 1'b1, 1'b1);
        wait_for_drain();

        // 32-bit words with a one-byte capacity, then a mode switch mid-block
        reg_write(xfse_pkg::REG_WIDTH_MODE, 32'd0);
        reg_write(xfse_pkg::REG_CAPACITY, 32'd1);
        send_item(64'hDEAD_BEEF_0000_0000, 1'b0, 1'b0);
        send_item(64'h0000_0000_FFFF_FFFF, 1'b0, 1'b0);
        send_item(64'hFFFF_FFFF_8000_0000, 1'b0, 1'b0);
        send_item(64'h0000_0000_0000_0001, 1'b0, 1'b0);
        wait_for_drain();
        reg_write(xfse_pkg::REG_WIDTH_MODE, 32'd1);
        send_item(64'hFFFF_FFFF_0000_0001, 1'b0, 1'b0);
        send_item(64'h0000_0001_0000_0001, 1'b0, 1'b1);
        wait_for_drain();

        while (random_items < 60) begin
            mode = 1'($urandom_range(0, 1));
            case ($urandom_range(0, 3))
                0:       cap = 16'd1;
                1:       cap = 16'hFFFF;
                2:       cap = 16'($urandom_range(2, 12));
                default: cap = 16'($urandom_range(13, 65534));
            endcase
            reg_write(xfse_pkg::REG_WIDTH_MODE, 32'(mode));
            reg_write(xfse_pkg::REG_CAPACITY, 32'(cap));
            phase_items = $urandom_range(10, 24);
            block_left  = $urandom_range(1, 12);
            for (int n = 0; n < phase_items; n++) begin
                nul = ($urandom_range(0, 9) == 0);
                eob = (block_left == 1) ||
                      (n == phase_items - 1 && $urandom_range(0, 7) != 0);
                case ($urandom_range(0, 7))
                    0: word = last_word;
                    1: word = {$urandom, $urandom};
                    2: word = last_word ^ (64'd1 << $urandom_range(0, 63));
                    3: word = last_word ^ ({$urandom, $urandom} >> $urandom_range(0, 63));
                    4: word = last_word ^ ({$urandom, $urandom} << $urandom_range(0, 63));
                    5: begin
                        case ($urandom_range(0, 3))
                            0:       word = '0;
                            1:       word = '1;
                            2:       word = 64'h8000_0000_0000_0000;
                            default: word = 64'd1;
                        endcase
                    end
                    default: word = last_word ^ (({$urandom, $urandom}
                                    >> $urandom_range(8, 63)) << $urandom_range(0, 20));
                endcase
                send_item(word, nul, eob);
                if (!nul) last_word = word;
                if (!nul || eob) random_items++;
                block_left = eob ? $urandom_range(1, 12) : block_left - 1;
            end
            wait_for_drain();
        end

        // back to back run with no stalls on either side, capacity runs out
        reg_write(xfse_pkg::REG_WIDTH_MODE, 32'd0);
        reg_write(xfse_pkg::REG_CAPACITY, 32'd4);
        tx_steady = 1'b1;
        rx_steady = 1'b1;
        for (int n = 0; n < 16; n++) begin
            send_item(64'h4049_0FDB_4049_0FDB ^ 64'(n), 1'b0, n == 15);
        end
        wait_for_drain();

        if (fail_total == 0 && waiting == 0) begin
            $display("TEST PASSED");
        end else begin
            $display("TEST FAILED");
        end
        $finish;
    end

endmodule
